/* hdl/kls_pkg.sv */
// Package for the keymap layer stack: widths, command codes, request and
// response structs, the cell command struct and the controller state type.
// No dependencies; every other file of the block imports it.
`default_nettype none

package kls_pkg;

	localparam int MAX_INDEX  = 7;
	localparam int NUM_LAYERS = 16;
	localparam int NUM_CELLS  = MAX_INDEX + 1;
	localparam int LAYER_W    = 4;
	localparam int DEPTH_W    = 3;
	localparam int ACTION_W   = 3;

	typedef logic [LAYER_W-1:0]  layer_t;
	typedef logic [DEPTH_W-1:0]  depth_t;
	typedef logic [ACTION_W-1:0] act_code_t;

	localparam act_code_t ACT_PUSH   = 3'd0;
	localparam act_code_t ACT_POP    = 3'd1;
	localparam act_code_t ACT_TOGGLE = 3'd2;
	localparam act_code_t ACT_SWITCH = 3'd3;
	localparam act_code_t ACT_CLEAR  = 3'd4;

	typedef struct packed {
		act_code_t action;
		layer_t    layer_id;
	} kls_req_t;

	typedef struct packed {
		layer_t top_layer;
		depth_t depth;
		logic   ignored;
		logic   removed;
	} kls_rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_REMOVE
	} cell_op_t;

	// Broadcast to every cell: what to do, the layer to store or search for,
	// the entry to load, and the current top index.
	typedef struct packed {
		cell_op_t op;
		layer_t   layer;
		depth_t   sel;
		depth_t   top;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REPORT
	} state_t;

	function automatic layer_t clamp_layer(input layer_t id);
		layer_t res;
		res = id;
		if (int'(id) >= NUM_LAYERS) begin
			res = LAYER_W'(NUM_LAYERS - 1);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* hdl/kls_cell.sv */
// One entry of the layer stack. Takes part in the top-down toggle search and
// shifts in its upper neighbor's entry when a removal closes the gap.
// Depends on kls_pkg.
`default_nettype none

module kls_cell #(
	parameter int IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kls_pkg::cell_cmd_t cmd,
	input  wire kls_pkg::layer_t   upper,
	input  wire logic              found_in,
	input  wire logic              hit_in,
	output kls_pkg::layer_t        entry,
	output logic                   found_out,
	output logic                   hit_out
);
	import kls_pkg::*;

	layer_t entry_q;
	logic   in_range;
	logic   below_top;
	logic   match;
	logic   first;

	// The base entry never takes part in the toggle search.
	assign in_range  = (IDX != 0) && (depth_t'(IDX) <= cmd.top);
	assign below_top = depth_t'(IDX) < cmd.top;
	assign match     = in_range && (entry_q == cmd.layer);

	// found runs downward from the top; hit runs upward from the first match,
	// so hit_out marks every cell at or above the entry being removed.
	assign first     = match && !found_in;
	assign found_out = found_in || match;
	assign hit_out   = hit_in || first;
	assign entry     = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			unique case (cmd.op)
				CELL_LOAD: begin
					if (cmd.sel == depth_t'(IDX)) begin
						entry_q <= cmd.layer;
					end
				end
				CELL_REMOVE: begin
					if (hit_out && below_top) begin
						entry_q <= upper;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/kls_ctrl.sv */
// Sequencer of the layer stack: takes a request, decodes it into a cell
// command, keeps the top index and holds the response register.
// Depends on kls_pkg.
`default_nettype none

module kls_ctrl (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   req_valid,
	output logic                                        req_stall,
	input  wire kls_pkg::kls_req_t                      req,
	output logic                                        rsp_valid,
	input  wire logic                                   rsp_stall,
	output kls_pkg::kls_rsp_t                           rsp,
	input  wire kls_pkg::layer_t [kls_pkg::NUM_CELLS-1:0] entries,
	input  wire logic                                   any_hit,
	output kls_pkg::cell_cmd_t                          cmd
);
	import kls_pkg::*;

	state_t   state_q, state_d;
	kls_req_t req_q;
	depth_t   top_q, top_d;
	logic     ignored_q, ignored_d;
	logic     removed_q, removed_d;
	kls_rsp_t rsp_q;
	logic     rsp_valid_q;
	logic     full;
	logic     rsp_free;
	layer_t   lay;

	assign full     = top_q == depth_t'(MAX_INDEX);
	assign lay      = clamp_layer(req_q.layer_id);
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = state_q != ST_IDLE;
		cmd.op    = CELL_HOLD;
		cmd.layer = lay;
		cmd.sel   = top_q;
		cmd.top   = top_q;
		top_d     = top_q;
		ignored_d = 1'b0;
		removed_d = 1'b0;
		if (state_q == ST_EXEC) begin
			unique case (req_q.action)
				ACT_PUSH: begin
					if (!full) begin
						cmd.op  = CELL_LOAD;
						cmd.sel = top_q + 1'b1;
						top_d   = top_q + 1'b1;
					end else begin
						ignored_d = 1'b1;
					end
				end
				ACT_POP: begin
					if (top_q != '0) begin
						top_d = top_q - 1'b1;
					end else begin
						ignored_d = 1'b1;
					end
				end
				ACT_TOGGLE: begin
					if (any_hit) begin
						cmd.op    = CELL_REMOVE;
						top_d     = top_q - 1'b1;
						removed_d = 1'b1;
					end else if (!full) begin
						cmd.op  = CELL_LOAD;
						cmd.sel = top_q + 1'b1;
						top_d   = top_q + 1'b1;
					end else begin
						ignored_d = 1'b1;
					end
				end
				ACT_SWITCH: begin
					cmd.op = CELL_LOAD;
				end
				ACT_CLEAR: begin
					cmd.op    = CELL_LOAD;
					cmd.sel   = '0;
					cmd.layer = '0;
					top_d     = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				top_q <= top_d;
			end
			if (state_q == ST_REPORT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_EXEC) begin
			ignored_q <= ignored_d;
			removed_q <= removed_d;
		end
		if (state_q == ST_REPORT && rsp_free) begin
			rsp_q.top_layer <= entries[top_q];
			rsp_q.depth     <= top_q;
			rsp_q.ignored   <= ignored_q;
			rsp_q.removed   <= removed_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_accept_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == ST_EXEC)
		else $error("accepted request did not start execution");

	a_exec_then_report: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_REPORT)
		else $error("execution step not followed by report");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC && cmd.op == CELL_REMOVE |=> top_q == $past(top_q) - 1'b1)
		else $error("toggle removal did not shrink the stack");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REPORT |-> !(ignored_q && removed_q))
		else $error("request both ignored and removed");

endmodule

`default_nettype wire

/* hdl/keymap_layer_stack.sv */
// Keymap layer stack: a row of entry cells and the sequencer that drives them.
// Depends on kls_pkg, kls_cell and kls_ctrl.
//
// Usage:
//   The request channel (req_valid, req_stall, req) carries one command:
//   push, pop, toggle, switch top or clear to base, with a layer number.
//   The response channel (rsp_valid, rsp_stall, rsp) returns one response per
//   request: the top layer and depth after the command, and the ignored and
//   removed flags. A request is taken when valid is high and stall is low.
//   A request is taken in the idle state, the cells search and update in
//   the next cycle (the execute state), and the response register loads in
//   the report state once it is free; the sequencer then returns to idle,
//   so a new request is taken only after the last one has been reported.
//   The sequencer walks three states; the toggle search ripples through
//   all eight cells within the execute cycle.
//   When the receiver stalls, the finished response stays in its register and
//   the next command waits in the report step until that register frees up.
//   Reset clears every entry to layer 0 and the depth to 0, leaving only the
//   base entry, and empties the response register.
`default_nettype none

module keymap_layer_stack (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_stall,
	input  wire kls_pkg::kls_req_t req,
	output logic              rsp_valid,
	input  wire logic         rsp_stall,
	output kls_pkg::kls_rsp_t rsp
);
	import kls_pkg::*;

	cell_cmd_t                   cmd;
	layer_t [NUM_CELLS-1:0]      entries;
	logic   [NUM_CELLS-1:0]      found_chain;
	logic   [NUM_CELLS-1:0]      hit_chain;
	logic                        any_hit;

	assign any_hit = found_chain[0];

	genvar gi;
	generate
		for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
			logic   found_in;
			logic   hit_in;
			layer_t upper;
			if (gi == NUM_CELLS - 1) begin : g_top
				assign found_in = 1'b0;
				assign upper    = '0;
			end else begin : g_mid
				assign found_in = found_chain[gi+1];
				assign upper    = entries[gi+1];
			end
			if (gi == 0) begin : g_base
				assign hit_in = 1'b0;
			end else begin : g_up
				assign hit_in = hit_chain[gi-1];
			end
			kls_cell #(
				.IDX(gi)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.upper    (upper),
				.found_in (found_in),
				.hit_in   (hit_in),
				.entry    (entries[gi]),
				.found_out(found_chain[gi]),
				.hit_out  (hit_chain[gi])
			);
		end
	endgenerate

	kls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.entries  (entries),
		.any_hit  (any_hit),
		.cmd      (cmd)
	);

	// Both chains must agree on whether the search found a match.
	a_chains_agree: assert property (@(posedge clk) disable iff (!arst_n)
		hit_chain[NUM_CELLS-1] == found_chain[0])
		else $error("search chains disagree on a match");

endmodule

`default_nettype wire
